### hdl/slid_pkg.sv
// ----------------------------------------------------------------------------
// slid_pkg
// Shared types and codes for the sorted list insert / delete block.
// ----------------------------------------------------------------------------
package slid_pkg;

    // operation selected by the input transaction
    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } t_op;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic               ins_en;
        logic               del_en;
        logic signed [31:0] value;
    } t_cmd;

endpackage

### hdl/slid_cell.sv
// ----------------------------------------------------------------------------
// slid_cell
// One slot of the sorted chain: compares its entry with the broadcast value
// and keeps, loads, or takes a neighbor's entry.
// ----------------------------------------------------------------------------
module slid_cell #(
    parameter int CNT_W = 5,
    parameter int INDEX = 0
) (
    input  logic               i_clk,
    input  slid_pkg::t_cmd     i_cmd,
    input  logic [CNT_W-1:0]   i_count,
    input  logic signed [31:0] i_left_value,
    input  logic               i_left_lt,
    input  logic signed [31:0] i_right_value,
    output logic signed [31:0] o_value,
    output logic               o_lt,
    output logic               o_eq
);
    import slid_pkg::*;

    localparam logic [CNT_W-1:0] IdxVal = CNT_W'(INDEX);

    logic signed [31:0] r_value;
    logic signed [31:0] n_value;
    logic               w_occupied;

    assign w_occupied = (i_count > IdxVal);
    assign o_lt       = w_occupied && (r_value < i_cmd.value);
    assign o_eq       = w_occupied && (r_value == i_cmd.value);
    assign o_value    = r_value;

    // cells below the insert / delete point keep their entry
    always_comb begin
        n_value = r_value;
        priority if (i_cmd.ins_en && !o_lt) begin
            if (i_left_lt) begin
                n_value = i_cmd.value;
            end else begin
                n_value = i_left_value;
            end
        end else if (i_cmd.del_en && !o_lt) begin
            n_value = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

### hdl/sorted_list_insert_delete.sv
// ----------------------------------------------------------------------------
// sorted_list_insert_delete
// Bounded ascending list of signed values with insert and delete-first-equal.
// ----------------------------------------------------------------------------
// The list is a row of CAPACITY compare-and-shift cells. Each transaction on
// the slave side is either an insert (tuser = 0) or a delete of the first
// entry equal to the value (tuser = 1). All cells compare against the value
// in parallel and shift one place right (insert) or left (delete) in the same
// clock, so one transaction is taken per cycle and its result appears on the
// master side in the cycle after acceptance, from the registered status and
// count. A pending result that is not taken holds off the next input. Every
// transaction returns one result: status (ok, not found, insert refused full),
// entry count after the operation, and the smallest entry with a valid flag
// (value reads zero when the list is empty). Entries beyond the count hold
// stale data and are never shown.
module sorted_list_insert_delete #(
    parameter int CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] value
    input  logic        i_s_tuser,   // [0] mode
    // master side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata    // [1:0] status, [6:2] entry_count,
                                     // [38:7] smallest_value, [39] smallest_valid
);
    import slid_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CapVal = CNT_W'(CAPACITY);

    // control state
    logic             r_out_valid;
    logic             n_out_valid;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    t_status          r_status;
    t_status          n_status;

    // chain signals
    logic signed [31:0] w_val [CAPACITY];
    logic               w_lt  [CAPACITY];
    logic [CAPACITY-1:0] w_eq;
    logic               w_found;
    logic               w_full;
    logic               w_accept;
    t_op                w_op;
    t_cmd               w_cmd;

    logic [31:0]        w_count_ext;
    logic signed [31:0] w_smallest;
    logic               w_nonempty;

    // handshake: a held result blocks new input
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_op       = t_op'(i_s_tuser);

    assign w_found = |w_eq;
    assign w_full  = (r_count >= CapVal);

    // command seen by every cell
    always_comb begin
        w_cmd.value  = i_s_tdata;
        w_cmd.ins_en = w_accept && (w_op == OP_INSERT) && !w_full;
        w_cmd.del_en = w_accept && (w_op == OP_DELETE) && w_found;
    end

    // row of cells, each linked to both neighbors
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [31:0] w_left_value;
        logic               w_left_lt;
        logic signed [31:0] w_right_value;

        if (g == 0) begin : g_head
            assign w_left_value = w_cmd.value;
            assign w_left_lt    = 1'b1;
        end else begin : g_body
            assign w_left_value = w_val[g-1];
            assign w_left_lt    = w_lt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right_value = w_val[g];
        end else begin : g_inner
            assign w_right_value = w_val[g+1];
        end

        slid_cell #(
            .CNT_W (CNT_W),
            .INDEX (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_cmd         (w_cmd),
            .i_count       (r_count),
            .i_left_value  (w_left_value),
            .i_left_lt     (w_left_lt),
            .i_right_value (w_right_value),
            .o_value       (w_val[g]),
            .o_lt          (w_lt[g]),
            .o_eq          (w_eq[g])
        );
    end

    // count, status and result valid
    always_comb begin
        n_count     = r_count;
        n_status    = r_status;
        n_out_valid = r_out_valid && !i_m_tready;
        if (w_cmd.ins_en) begin
            n_count = r_count + 1'b1;
        end else if (w_cmd.del_en) begin
            n_count = r_count - 1'b1;
        end
        if (w_accept) begin
            n_out_valid = 1'b1;
            unique case (w_op)
                OP_INSERT: n_status = w_full  ? ST_FULL : ST_OK;
                OP_DELETE: n_status = w_found ? ST_OK   : ST_NOT_FOUND;
                default:   n_status = ST_OK;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_status    <= ST_OK;
        end else begin
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
            r_status    <= n_status;
        end
    end

    // result fields read straight from the list state, which holds while
    // a result waits
    assign w_count_ext = 32'(r_count);
    assign w_nonempty  = (r_count != '0);
    assign w_smallest  = w_nonempty ? w_val[0] : 32'sd0;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {w_nonempty, w_smallest, w_count_ext[4:0], r_status};

`ifndef NO_ASSERTIONS
    // count never runs past the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CapVal)
        else $error("entry count exceeds capacity");

    // a refused insert is only reported while the list is full
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status == ST_FULL)) |-> (r_count == CapVal))
        else $error("full status with free slots");

    // a successful delete removes exactly one entry
    a_delete_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.del_en |=> (r_count == $past(r_count) - 1'b1))
        else $error("delete did not shrink the list by one");

    // head of the list stays in ascending order
    a_head_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2)) |-> (w_val[0] <= w_val[1]))
        else $error("list head out of order");
`endif

endmodule
